// ===== rtl/tlbrl_pkg.sv =====
// ----------------------------------------------------------------------------
// tlbrl_pkg
// Shared types and constants of the recency-list translation table.
// ----------------------------------------------------------------------------
`default_nettype none

package tlbrl_pkg;

  // table geometry and field widths
  localparam int DEPTH      = 16;
  localparam int PAGE_BITS  = 20;
  localparam int PID_BITS   = 16;
  localparam int FRAME_BITS = 16;

  // position index and live-count widths
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // capacity register width and the width used to compare it with the count
  localparam int CAP_W  = 5;
  localparam int CAPX_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // stream payload widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index, taken from paddr bit 2
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_LRU      = 1'b1;

  // operation codes of the mode field
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // one stored translation
  typedef struct packed {
    logic [FRAME_BITS-1:0] frame;
    logic [PID_BITS-1:0]   pid;
    logic [PAGE_BITS-1:0]  page;
  } entry_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic cmp;
    logic upd;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_hold;
  } sts_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/tlbrl_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlbrl_ctrl
// Sequencer: capture one item, compare against all entries, then update.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbrl_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  tlbrl_pkg::sts_t     sts,
  output tlbrl_pkg::cmd_t     cmd
);

  tlbrl_pkg::state_t state_r;
  tlbrl_pkg::state_t state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tlbrl_pkg::ST_IDLE: begin
        if (in_tvalid) state_nxt = tlbrl_pkg::ST_CMP;
      end
      tlbrl_pkg::ST_CMP: begin
        state_nxt = tlbrl_pkg::ST_UPD;
      end
      tlbrl_pkg::ST_UPD: begin
        if (!sts.out_hold) state_nxt = tlbrl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tlbrl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlbrl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  assign in_tready = (state_r == tlbrl_pkg::ST_IDLE);
  assign cmd.load  = (state_r == tlbrl_pkg::ST_IDLE) && in_tvalid;
  assign cmd.cmp   = (state_r == tlbrl_pkg::ST_CMP);
  assign cmd.upd   = (state_r == tlbrl_pkg::ST_UPD) && !sts.out_hold;

endmodule

`default_nettype wire

// ===== rtl/tlbrl_dp.sv =====
// ----------------------------------------------------------------------------
// tlbrl_dp
// Entry list, parallel key compare, list reorder and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbrl_dp (
  input  wire                                clk,
  input  wire                                rst_n,
  input  tlbrl_pkg::cmd_t                    cmd,
  output tlbrl_pkg::sts_t                    sts,
  input  wire                                in_mode,
  input  wire [tlbrl_pkg::PAGE_BITS-1:0]     in_page,
  input  wire [tlbrl_pkg::PID_BITS-1:0]      in_pid,
  input  wire [tlbrl_pkg::FRAME_BITS-1:0]    in_frame,
  input  wire [tlbrl_pkg::CAP_W-1:0]         capacity,
  input  wire                                lru_on_hit,
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic                               res_hit,
  output logic [tlbrl_pkg::FRAME_BITS-1:0]   res_frame,
  output logic                               res_entry_valid,
  output logic                               res_evicted,
  output logic [tlbrl_pkg::PID_BITS-1:0]     res_evicted_pid
);

  localparam int DEPTH  = tlbrl_pkg::DEPTH;
  localparam int IDX_W  = tlbrl_pkg::IDX_W;
  localparam int CNT_W  = tlbrl_pkg::CNT_W;
  localparam int CAPX_W = tlbrl_pkg::CAPX_W;

  // captured request
  logic                  req_mode_r;
  tlbrl_pkg::entry_t     req_r;

  // list storage, position 0 newest
  tlbrl_pkg::entry_t     ent_r   [DEPTH];
  tlbrl_pkg::entry_t     ent_nxt [DEPTH];
  logic [CNT_W-1:0]      count_r;
  logic [CNT_W-1:0]      count_nxt;

  // registered match vector
  logic [DEPTH-1:0]      match_r;
  logic [DEPTH-1:0]      match_nxt;

  // update-stage decode
  logic [IDX_W-1:0]      hit_idx;
  logic                  any_hit;
  logic [CAPX_W-1:0]     eff_cap;
  logic                  evict;
  logic [IDX_W-1:0]      old_idx;

  // result register
  logic                          out_valid_r;
  logic                          res_hit_r;
  logic [tlbrl_pkg::FRAME_BITS-1:0] res_frame_r;
  logic                          res_evicted_r;
  logic [tlbrl_pkg::PID_BITS-1:0]   res_evicted_pid_r;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_mode_r    <= in_mode;
      req_r.page    <= in_page;
      req_r.pid     <= in_pid;
      req_r.frame   <= in_frame;
    end
  end

  // key compare against all live entries
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      match_nxt[i] = (CNT_W'(i) < count_r) &&
                     (ent_r[i].page == req_r.page) &&
                     (ent_r[i].pid == req_r.pid);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      match_r <= match_nxt;
    end
  end

  // newest matching position
  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) hit_idx = IDX_W'(i);
    end
  end
  assign any_hit = |match_r;

  // effective capacity, clamped to 1..DEPTH
  always_comb begin
    eff_cap = CAPX_W'(capacity);
    if (capacity == '0) eff_cap = CAPX_W'(1);
    if (eff_cap > CAPX_W'(DEPTH)) eff_cap = CAPX_W'(DEPTH);
  end

  // insert evicts the oldest entry when the table is at capacity
  assign evict   = (CAPX_W'(count_r) >= eff_cap) && (count_r != '0);
  assign old_idx = IDX_W'(count_r - CNT_W'(1));

  // list reorder
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i] = ent_r[i];
    end
    count_nxt = count_r;
    if (cmd.upd) begin
      if (req_mode_r == tlbrl_pkg::OP_INSERT) begin
        for (int i = 1; i < DEPTH; i++) begin
          ent_nxt[i] = ent_r[i-1];
        end
        ent_nxt[0] = req_r;
        count_nxt  = evict ? count_r : count_r + CNT_W'(1);
      end else if (any_hit && lru_on_hit) begin
        for (int i = 1; i < DEPTH; i++) begin
          if (IDX_W'(i) <= hit_idx) ent_nxt[i] = ent_r[i-1];
        end
        ent_nxt[0] = ent_r[hit_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_r[i] <= ent_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // result register, held until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.upd) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      if (req_mode_r == tlbrl_pkg::OP_INSERT) begin
        res_hit_r         <= 1'b0;
        res_frame_r       <= '0;
        res_evicted_r     <= evict;
        res_evicted_pid_r <= evict ? ent_r[old_idx].pid : '0;
      end else begin
        res_hit_r         <= any_hit;
        res_frame_r       <= any_hit ? ent_r[hit_idx].frame : '0;
        res_evicted_r     <= 1'b0;
        res_evicted_pid_r <= '0;
      end
    end
  end

  assign sts.out_hold    = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign res_hit         = res_hit_r;
  assign res_frame       = res_frame_r;
  assign res_entry_valid = res_hit_r;
  assign res_evicted     = res_evicted_r;
  assign res_evicted_pid = res_evicted_pid_r;

endmodule

`default_nettype wire

// ===== rtl/tlb_recency_list_fifo_lru_unit.sv =====
// ----------------------------------------------------------------------------
// tlb_recency_list_fifo_lru_unit
// Fully associative translation table with FIFO or LRU replacement.
// ----------------------------------------------------------------------------
// Each lookup or insert passes through these steps in order: the item is
// captured, then all entries are compared against the key at once and the
// match vector is registered, then the newest match is picked, the entry
// list is shifted and the result is loaded into the output register.
// The controller handles one item at a time and accepts no new item until
// the last one has reached the output register; a result that is not taken
// holds the update step until its transfer completes. The user must write
// capacity and the LRU bit over APB only while idle; the block does not enforce it.
`default_nettype none

module tlb_recency_list_fifo_lru_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // input stream
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // page_number[19:0], process_id[35:20], frame_number[51:36], zero pad
  input  wire [tlbrl_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode[0]
  input  wire                                 in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // hit[0], frame_out[16:1], entry_valid[17], evicted[18],
  // evicted_pid[34:19], zero pad
  output logic [tlbrl_pkg::OUT_DATA_W-1:0]    out_tdata,
  // configuration
  input  wire                                 cfg_psel,
  input  wire                                 cfg_penable,
  input  wire                                 cfg_pwrite,
  input  wire [tlbrl_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  wire [tlbrl_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [tlbrl_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                cfg_pready
);

  tlbrl_pkg::cmd_t                 cmd;
  tlbrl_pkg::sts_t                 sts;
  logic [tlbrl_pkg::CAP_W-1:0]     capacity_r;
  logic                            lru_r;
  logic                            cfg_wr;
  logic                            res_hit;
  logic [tlbrl_pkg::FRAME_BITS-1:0] res_frame;
  logic                            res_entry_valid;
  logic                            res_evicted;
  logic [tlbrl_pkg::PID_BITS-1:0]  res_evicted_pid;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= tlbrl_pkg::CAP_W'(16);
      lru_r      <= 1'b1;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == tlbrl_pkg::REG_CAPACITY) begin
        capacity_r <= cfg_pwdata[tlbrl_pkg::CAP_W-1:0];
      end else begin
        lru_r <= cfg_pwdata[0];
      end
    end
  end

  // register readback
  always_comb begin
    case (cfg_paddr[2])
      tlbrl_pkg::REG_CAPACITY: cfg_prdata = tlbrl_pkg::CFG_DATA_W'(capacity_r);
      tlbrl_pkg::REG_LRU:      cfg_prdata = tlbrl_pkg::CFG_DATA_W'(lru_r);
      default:                 cfg_prdata = '0;
    endcase
  end

  // controller
  tlbrl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  tlbrl_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_mode         (in_tuser),
    .in_page         (in_tdata[19:0]),
    .in_pid          (in_tdata[35:20]),
    .in_frame        (in_tdata[51:36]),
    .capacity        (capacity_r),
    .lru_on_hit      (lru_r),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .res_hit         (res_hit),
    .res_frame       (res_frame),
    .res_entry_valid (res_entry_valid),
    .res_evicted     (res_evicted),
    .res_evicted_pid (res_evicted_pid)
  );

  // result packing
  assign out_tdata = {5'b0, res_evicted_pid, res_evicted, res_entry_valid,
                      res_frame, res_hit};

endmodule

`default_nettype wire

// ===== rtl/tlbrl_chk.sv =====
// ----------------------------------------------------------------------------
// tlbrl_chk
// Port-level checks of the translation table result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module tlbrl_chk (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              out_tvalid,
  input  wire                              out_tready,
  input  wire [tlbrl_pkg::OUT_DATA_W-1:0]  out_tdata
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // the validity mark follows the hit flag
  a_valid_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[17] == out_tdata[0])
    else $error("entry_valid differs from hit");

  // a miss or insert returns no frame
  a_miss_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[16:1] == 16'd0)
    else $error("frame_out set without hit");

  // no eviction together with a hit, pid only with eviction
  a_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[18] && out_tdata[0]) &&
                   (out_tdata[18] || out_tdata[34:19] == 16'd0))
    else $error("eviction fields inconsistent");

endmodule

bind tlb_recency_list_fifo_lru_unit tlbrl_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the recency-list translation table. A driver
// presents lookups and inserts from a queue of pending requests. Each
// accepted transfer runs through an in-bench copy of the table, and the
// result it gives is queued. A monitor compares every result transfer,
// field by field, with the oldest queued result. Capacity and the
// FIFO/LRU mode change between phases while the table is idle.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int POOL_MAX       = 32;

  localparam int DEPTH      = tlbrl_pkg::DEPTH;
  localparam int PAGE_BITS  = tlbrl_pkg::PAGE_BITS;
  localparam int PID_BITS   = tlbrl_pkg::PID_BITS;
  localparam int FRAME_BITS = tlbrl_pkg::FRAME_BITS;
  localparam int IN_DATA_W  = tlbrl_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = tlbrl_pkg::OUT_DATA_W;
  localparam int CFG_ADDR_W = tlbrl_pkg::CFG_ADDR_W;
  localparam int CFG_DATA_W = tlbrl_pkg::CFG_DATA_W;

  // one request as it goes on the input stream
  typedef struct {
    logic              op;
    tlbrl_pkg::entry_t ent;
  } xlate_req_t;

  // result fields, hit in the lowest bit as on out_tdata
  typedef struct packed {
    logic [PID_BITS-1:0]   evicted_pid;
    logic                  evicted;
    logic                  entry_valid;
    logic [FRAME_BITS-1:0] frame_out;
    logic                  hit;
  } xlate_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // stimulus and scoreboard storage
  xlate_req_t        pending_reqs[$];
  xlate_result_t     expected_results[$];
  tlbrl_pkg::entry_t key_pool[$];
  xlate_req_t        drv_req;
  int                fail_count = 0;
  int                stall_cycles;
  bit                no_idle = 1'b0;

  // in-bench copy of the table and its registers
  tlbrl_pkg::entry_t tbl[DEPTH];
  int                live_cnt = 0;
  logic [4:0]        cap_reg = 5'd16;
  logic              lru_reg = 1'b1;

  always #4 clk = ~clk;

  tlb_recency_list_fifo_lru_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // translate one request and update the table copy
  function automatic xlate_result_t translate(input logic op,
                                              input tlbrl_pkg::entry_t key);
    xlate_result_t     r;
    tlbrl_pkg::entry_t found;
    int                n;
    int                cap;
    int                hit_at;
    int                i;
    r = '0;
    n = live_cnt;
    cap = int'(cap_reg);
    if (cap < 1) cap = 1;
    if (cap > DEPTH) cap = DEPTH;
    if (op == tlbrl_pkg::OP_INSERT) begin
      // full table drops only its oldest entry
      if (n >= cap && n > 0) begin
        r.evicted = 1'b1;
        r.evicted_pid = tbl[n-1].pid;
        n--;
      end
      for (i = n; i > 0; i--) tbl[i] = tbl[i-1];
      tbl[0] = key;
      live_cnt = n + 1;
    end else begin
      // newest matching copy wins
      hit_at = -1;
      for (i = 0; i < n; i++) begin
        if (hit_at < 0 && tbl[i].page == key.page && tbl[i].pid == key.pid) hit_at = i;
      end
      if (hit_at >= 0) begin
        found = tbl[hit_at];
        r.hit = 1'b1;
        r.entry_valid = 1'b1;
        r.frame_out = found.frame;
        if (lru_reg) begin
          for (i = hit_at; i > 0; i--) tbl[i] = tbl[i-1];
          tbl[0] = found;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // input driver: holds a request until its transfer, idles at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(translate(drv_req.op, drv_req.ent));
      end
      if (!in_tvalid || in_tready) begin
        if (pending_reqs.size() != 0 && (no_idle || $urandom_range(99) >= 31)) begin
          drv_req = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= drv_req.op;
          in_tdata <= {{(IN_DATA_W - $bits(tlbrl_pkg::entry_t)){1'b0}}, drv_req.ent};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and random back-pressure
  always @(posedge clk) begin
    xlate_result_t got;
    xlate_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(xlate_result_t)-1:0];
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected, data %h", out_tdata));
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b", got.hit, want.hit));
          if (got.frame_out !== want.frame_out)
            report_mismatch($sformatf("frame_out %h, want %h", got.frame_out,
                                      want.frame_out));
          if (got.entry_valid !== want.entry_valid)
            report_mismatch($sformatf("entry_valid %b, want %b", got.entry_valid,
                                      want.entry_valid));
          if (got.evicted !== want.evicted)
            report_mismatch($sformatf("evicted %b, want %b", got.evicted, want.evicted));
          if (got.evicted_pid !== want.evicted_pid)
            report_mismatch($sformatf("evicted_pid %h, want %h", got.evicted_pid,
                                      want.evicted_pid));
        end
      end
      out_tready <= no_idle || ($urandom_range(99) >= 31);
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // queue one request; inserted keys feed later lookups
  task automatic add_req(input logic op, input logic [PAGE_BITS-1:0] page,
                         input logic [PID_BITS-1:0] pid, input logic [FRAME_BITS-1:0] frame);
    xlate_req_t r;
    r.op = op;
    r.ent.page = page;
    r.ent.pid = pid;
    r.ent.frame = frame;
    pending_reqs.push_back(r);
    if (op == tlbrl_pkg::OP_INSERT) begin
      key_pool.push_back(r.ent);
      if (key_pool.size() > POOL_MAX) void'(key_pool.pop_front());
    end
  endtask

  // inserts, and lookups mostly of known keys with some near misses and random keys
  task automatic add_random_req(input bit narrow, input logic [PAGE_BITS-1:0] base_page,
                                input logic [PID_BITS-1:0] base_pid);
    tlbrl_pkg::entry_t e;
    int                pick;
    e.page = narrow ? base_page ^ PAGE_BITS'($urandom_range(3)) : PAGE_BITS'($urandom);
    e.pid = narrow ? base_pid ^ PID_BITS'($urandom_range(3)) : PID_BITS'($urandom);
    e.frame = FRAME_BITS'($urandom);
    if ($urandom_range(99) < 45) begin
      add_req(tlbrl_pkg::OP_INSERT, e.page, e.pid, e.frame);
    end else begin
      pick = $urandom_range(99);
      if (key_pool.size() != 0 && pick < 75) begin
        e = key_pool[$urandom_range(key_pool.size() - 1)];
        if (pick >= 60) begin
          // one key bit off
          if ($urandom_range(1)) e.page ^= PAGE_BITS'(1) << $urandom_range(PAGE_BITS - 1);
          else e.pid ^= PID_BITS'(1) << $urandom_range(PID_BITS - 1);
        end
      end
      add_req(tlbrl_pkg::OP_LOOKUP, e.page, e.pid, FRAME_BITS'($urandom));
    end
  endtask

  // apb write: setup then access, register updates on the access edge
  task automatic write_cfg(input logic idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == tlbrl_pkg::REG_CAPACITY) cap_reg = val[4:0];
    else lru_reg = val[0];
  endtask

  // wait until every request went out and every result came back
  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic start_phase(input logic [4:0] cap, input logic lru, input bit quiet);
    wait_idle();
    write_cfg(tlbrl_pkg::REG_CAPACITY, CFG_DATA_W'(cap));
    write_cfg(tlbrl_pkg::REG_LRU, CFG_DATA_W'(lru));
    @(negedge clk);
    no_idle = quiet;
  endtask

  // stimulus sequence
  initial begin
    logic [4:0]           cap_extremes[5];
    logic [PAGE_BITS-1:0] base_page;
    logic [PID_BITS-1:0]  base_pid;
    int                   ph;
    cap_extremes = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd17};
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= tlbrl_pkg::OP_LOOKUP;
    out_tready <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: empty lookups, extreme keys, duplicates, near misses
    add_req(tlbrl_pkg::OP_LOOKUP, '0, '0, '0);
    add_req(tlbrl_pkg::OP_LOOKUP, '1, '1, '1);
    add_req(tlbrl_pkg::OP_INSERT, '1, '1, '1);
    add_req(tlbrl_pkg::OP_INSERT, '0, '0, '0);
    add_req(tlbrl_pkg::OP_INSERT, 20'h12345, 16'hABCD, 16'h1111);
    add_req(tlbrl_pkg::OP_INSERT, 20'h12345, 16'hABCD, 16'h2222);
    add_req(tlbrl_pkg::OP_LOOKUP, '1, '1, '0);
    add_req(tlbrl_pkg::OP_LOOKUP, 20'h12345, 16'hABCD, '1);
    add_req(tlbrl_pkg::OP_LOOKUP, 20'h12345, 16'hABCC, '0);
    add_req(tlbrl_pkg::OP_LOOKUP, 20'h12344, 16'hABCD, '0);
    add_req(tlbrl_pkg::OP_LOOKUP, '0, '0, '1);

    // capacity dropped below the live count, fifo order
    start_phase(5'd2, 1'b0, 1'b0);
    add_req(tlbrl_pkg::OP_INSERT, 20'h00001, 16'h0001, 16'h0101);
    add_req(tlbrl_pkg::OP_LOOKUP, '0, '0, '0);
    add_req(tlbrl_pkg::OP_INSERT, 20'h00002, 16'h0002, 16'h0202);
    add_req(tlbrl_pkg::OP_LOOKUP, 20'h12345, 16'hABCD, '0);

    // capacity zero acts as one
    start_phase(5'd0, 1'b1, 1'b0);
    add_req(tlbrl_pkg::OP_INSERT, 20'hFFFFE, 16'h8000, 16'h8001);
    add_req(tlbrl_pkg::OP_LOOKUP, 20'hFFFFE, 16'h8000, '0);
    add_req(tlbrl_pkg::OP_INSERT, 20'h80000, 16'h7FFF, 16'h7FFE);
    add_req(tlbrl_pkg::OP_LOOKUP, 20'hFFFFE, 16'h8000, '0);

    // capacity above the depth saturates
    start_phase(5'd31, 1'b0, 1'b0);
    repeat (4) add_req(tlbrl_pkg::OP_INSERT, PAGE_BITS'($urandom), PID_BITS'($urandom),
                       FRAME_BITS'($urandom));
    add_req(tlbrl_pkg::OP_LOOKUP, 20'h80000, 16'h7FFF, '0);

    // random phases with a range of settings, one without any idling
    for (ph = 0; ph < 10; ph++) begin
      start_phase(ph < 5 ? cap_extremes[ph] : 5'($urandom_range(31)),
                  1'($urandom_range(1)), ph == 6);
      base_page = PAGE_BITS'($urandom);
      base_pid = PID_BITS'($urandom);
      repeat (130) add_random_req(ph % 2 == 1, base_page, base_pid);
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/tlbrl_pkg.sv
rtl/tlbrl_ctrl.sv
rtl/tlbrl_dp.sv
rtl/tlb_recency_list_fifo_lru_unit.sv
rtl/tlbrl_chk.sv
test/tb_top.sv
